>>> sv/ctas_pkg.sv
package ctas_pkg;

	localparam int POS_FRAC_BITS   = 8;
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int HEAD_FRAC       = 21;
	localparam int ATAN_SLOTS      = 24;
	localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;
	localparam int HEAD_SHIFT      = 30 - HEAD_FRAC;
	localparam int RATE_SHIFT      = HEAD_SHIFT + 9;

	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] ROLL_LIM    = 34'sd655911555;
	localparam logic signed [26:0] PI_H        = 27'sd6588397;
	localparam logic signed [26:0] TWO_PI_H    = 27'sd13176794;
	localparam logic [11:0]        PITCH_LIM   = 12'd2502;
	localparam logic signed [59:0] GRAV_X      = 60'sd2696552267120;
	localparam logic signed [41:0] RATE_LIM    = 42'sd1099511627776;
	localparam logic signed [16:0] G_OFFSET    = 17'sd1 <<< (POS_FRAC_BITS + 1);

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_ENTER,
		DP_MUL_PN,
		DP_MUL_PE,
		DP_MUL_VN,
		DP_MUL_VE,
		DP_SQRT_LD,
		DP_SQRT_STEP,
		DP_DIST,
		DP_SPD,
		DP_G,
		DP_DIV_LD,
		DP_DIV_STEP,
		DP_RATE,
		DP_MUL_RL,
		DP_MUL_RH,
		DP_ROLL_LD,
		DP_CORDIC,
		DP_ROLL,
		DP_YAW_LD,
		DP_YAW,
		DP_SC_LD,
		DP_MUL_C,
		DP_MUL_S,
		DP_FINISH,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] step;
	} dp_cmd_t;

	function automatic int cordic_steps(input int s);
		return (s < ATAN_SLOTS) ? s : ATAN_SLOTS;
	endfunction

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] a;
		unique case (i)
			5'd0:    a = 34'sd843314857;
			5'd1:    a = 34'sd497837829;
			5'd2:    a = 34'sd263043837;
			5'd3:    a = 34'sd133525159;
			5'd4:    a = 34'sd67021687;
			5'd5:    a = 34'sd33543516;
			5'd6:    a = 34'sd16775851;
			5'd7:    a = 34'sd8388437;
			5'd8:    a = 34'sd4194283;
			5'd9:    a = 34'sd2097149;
			5'd10:   a = 34'sd1048576;
			5'd11:   a = 34'sd524288;
			5'd12:   a = 34'sd262144;
			5'd13:   a = 34'sd131072;
			5'd14:   a = 34'sd65536;
			5'd15:   a = 34'sd32768;
			5'd16:   a = 34'sd16384;
			5'd17:   a = 34'sd8192;
			5'd18:   a = 34'sd4096;
			5'd19:   a = 34'sd2048;
			5'd20:   a = 34'sd1024;
			5'd21:   a = 34'sd512;
			5'd22:   a = 34'sd256;
			5'd23:   a = 34'sd128;
			default: a = 34'sd0;
		endcase
		return a;
	endfunction

	// Length of the unit vector after the vectoring iterations, in Q30.
	function automatic longint cordic_gain(input int n);
		longint x;
		longint y;
		longint xs;
		longint ys;
		x = longint'(1) <<< 30;
		y = 0;
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
			end else begin
				x = x - ys;
				y = y + xs;
			end
		end
		if (x <= 0) begin
			x = 1;
		end
		return x;
	endfunction

endpackage

>>> sv/circle_track_attitude_setpoint.sv
// Channel   Direction  Signals                          Beat contents
// s_axis    in         tvalid tready tdata[80] tuser    one enter or run item
// m_axis    out        tvalid tready tdata[80]          one setpoint result
// cfg       in         valid ready index data[15]       one register write
//
// An enter item gives no result.
// A run item goes through the 56-step divider and makes three passes through the
// shared rotation unit before its result is registered.
// Reset clears the kept heading and loads the register defaults.
// A waiting result holds in the output register; the next item is already
// accepted and stalls only at its own output step.
module circle_track_attitude_setpoint #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// yaw_angle[14:0], pos_north[30:15], pos_east[46:31], vel_north[62:47],
	// vel_east[78:63], zero fill
	input  logic [79:0] s_axis_tdata,
	// operation[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// carrot_first[15:0], carrot_second[31:16], roll_cmd[44:32],
	// pitch_cmd[57:45], yaw_cmd[72:58], zero fill
	output logic [79:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	ctas_pkg::dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ctas_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_run    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ctas_datapath #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata)
	);

endmodule

>>> sv/ctas_datapath.sv
module ctas_datapath #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctas_pkg::dp_cmd_t  cmd,
	input  logic [79:0]        in_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [14:0]        cfg_data,
	output logic [79:0]        out_data
);

	localparam int NSTEPS = ctas_pkg::cordic_steps(CORDIC_STEPS);
	localparam longint KGAIN = ctas_pkg::cordic_gain(NSTEPS);
	localparam logic signed [33:0] KINV = 34'((longint'(1) <<< 60) / KGAIN);

	logic signed [14:0] yaw_q;
	logic signed [15:0] pn_q, pe_q, vn_q, ve_q;
	logic [11:0]        pm_q;
	logic [14:0]        rad_q;
	logic signed [23:0] head_q;
	logic signed [51:0] prod_q;
	logic signed [59:0] acc_q;
	logic [31:0]        sv_q, sr_q, sb_q;
	logic [15:0]        dist_q, spd_q;
	logic signed [16:0] g_q;
	logic [55:0]        dnum_q;
	logic [23:0]        drem_q, dden_q;
	logic signed [41:0] rate_q;
	logic signed [59:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic               vec_q, neg_q, zero_q;
	logic signed [15:0] car1_q, car2_q;
	logic signed [12:0] roll_q, pitch_q;
	logic signed [14:0] yawc_q;
	logic [79:0]        out_q;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [51:0] mul_p;
	logic signed [59:0] xs, ys;
	logic signed [33:0] at;
	logic               up;
	logic [32:0]        sq_t;
	logic [24:0]        rem2;
	logic               ge;
	logic [15:0]        gmag;
	logic               qbig;
	logic [40:0]        qmag;
	logic signed [59:0] yi, xi;
	logic signed [33:0] zh;
	logic signed [34:0] zn, zc, tr, ty;
	logic [11:0]        pmc;

	function automatic logic signed [23:0] wrap_head(input logic signed [25:0] h);
		logic signed [26:0] t;
		t = 27'(h) + ctas_pkg::PI_H;
		if (t >= ctas_pkg::TWO_PI_H) begin
			t = t - ctas_pkg::TWO_PI_H;
		end else if (t < 0) begin
			t = t + ctas_pkg::TWO_PI_H;
		end
		return 24'(t - ctas_pkg::PI_H);
	endfunction

	function automatic logic signed [34:0] tshr(input logic signed [34:0] v);
		logic signed [34:0] r;
		if (v < 0) begin
			r = -((-v) >>> ctas_pkg::ANG_SHIFT);
		end else begin
			r = v >>> ctas_pkg::ANG_SHIFT;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] carrot(input logic signed [51:0] p);
		logic signed [52:0] t;
		t = (53'(p) + (53'sd1 <<< 29)) >>> 30;
		t = -t;
		if (t > 53'sd32767) begin
			t = 53'sd32767;
		end else if (t < -53'sd32768) begin
			t = -53'sd32768;
		end
		return 16'(t);
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			ctas_pkg::DP_MUL_PN: begin
				mul_a = 34'(pn_q);
				mul_b = 18'(pn_q);
			end
			ctas_pkg::DP_MUL_PE: begin
				mul_a = 34'(pe_q);
				mul_b = 18'(pe_q);
			end
			ctas_pkg::DP_MUL_VN: begin
				mul_a = 34'(vn_q);
				mul_b = 18'(vn_q);
			end
			ctas_pkg::DP_MUL_VE: begin
				mul_a = 34'(ve_q);
				mul_b = 18'(ve_q);
			end
			ctas_pkg::DP_MUL_RL: begin
				mul_a = $signed({13'b0, rate_q[20:0]});
				mul_b = $signed({2'b0, spd_q});
			end
			ctas_pkg::DP_MUL_RH: begin
				mul_a = 34'($signed(rate_q[41:21]));
				mul_b = $signed({2'b0, spd_q});
			end
			ctas_pkg::DP_MUL_C: begin
				mul_a = neg_q ? -$signed(x_q[33:0]) : $signed(x_q[33:0]);
				mul_b = $signed({3'b0, rad_q});
			end
			ctas_pkg::DP_MUL_S: begin
				mul_a = neg_q ? -$signed(y_q[33:0]) : $signed(y_q[33:0]);
				mul_b = $signed({3'b0, rad_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 52'(mul_a) * 52'(mul_b);
	end

	always_comb begin
		xs   = x_q >>> cmd.step;
		ys   = y_q >>> cmd.step;
		at   = ctas_pkg::atan_q30(cmd.step);
		up   = vec_q ? (y_q > 0) : z_q[33];
		sq_t = {1'b0, sr_q} + {1'b0, sb_q};
		rem2 = {drem_q, dnum_q[55]};
		ge   = rem2 >= {1'b0, dden_q};
		gmag = g_q[16] ? 16'(-g_q) : 16'(g_q);
		qbig = (|dnum_q[55:41]) || (dnum_q[40] && (|dnum_q[39:0]));
		qmag = qbig ? 41'h100_0000_0000 : dnum_q[40:0];
		xi   = 60'(vn_q) <<< 14;
		yi   = 60'(ve_q) <<< 14;
		zh   = 34'(head_q) <<< ctas_pkg::HEAD_SHIFT;
		zn   = -35'(z_q);
		if (zn > 35'(ctas_pkg::ROLL_LIM)) begin
			zc = 35'(ctas_pkg::ROLL_LIM);
		end else if (zn < -35'(ctas_pkg::ROLL_LIM)) begin
			zc = -35'(ctas_pkg::ROLL_LIM);
		end else begin
			zc = zn;
		end
		tr = tshr(zc);
		ty = tshr(35'(z_q));
		pmc = (pm_q > ctas_pkg::PITCH_LIM) ? ctas_pkg::PITCH_LIM : pm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q   <= 12'd1024;
			rad_q  <= 15'd768;
			head_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index) begin
					rad_q <= cfg_data;
				end else begin
					pm_q <= cfg_data[11:0];
				end
			end
			if (cmd.op == ctas_pkg::DP_ENTER) begin
				head_q <= wrap_head(26'(yaw_q) <<<
					(ctas_pkg::HEAD_FRAC - ctas_pkg::ANGLE_FRAC_BITS));
			end else if (cmd.op == ctas_pkg::DP_FINISH) begin
				head_q <= wrap_head(26'(head_q) + 26'(rate_q >>> ctas_pkg::RATE_SHIFT));
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ctas_pkg::DP_LOAD: begin
				yaw_q <= $signed(in_data[14:0]);
				pn_q  <= $signed(in_data[30:15]);
				pe_q  <= $signed(in_data[46:31]);
				vn_q  <= $signed(in_data[62:47]);
				ve_q  <= $signed(in_data[78:63]);
			end
			ctas_pkg::DP_MUL_PN, ctas_pkg::DP_MUL_VN, ctas_pkg::DP_MUL_RL,
			ctas_pkg::DP_MUL_C: begin
				prod_q <= mul_p;
			end
			ctas_pkg::DP_MUL_PE, ctas_pkg::DP_MUL_VE, ctas_pkg::DP_MUL_RH: begin
				acc_q  <= 60'(prod_q);
				prod_q <= mul_p;
			end
			ctas_pkg::DP_SQRT_LD: begin
				sv_q <= acc_q[31:0] + prod_q[31:0];
				sr_q <= '0;
				sb_q <= 32'h4000_0000;
			end
			ctas_pkg::DP_SQRT_STEP: begin
				if ({1'b0, sv_q} >= sq_t) begin
					sv_q <= sv_q - sq_t[31:0];
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			ctas_pkg::DP_DIST: begin
				dist_q <= sr_q[15:0];
			end
			ctas_pkg::DP_SPD: begin
				spd_q <= sr_q[15:0];
			end
			ctas_pkg::DP_G: begin
				g_q <= $signed({1'b0, dist_q}) - $signed({2'b0, rad_q}) + ctas_pkg::G_OFFSET;
			end
			ctas_pkg::DP_DIV_LD: begin
				dnum_q <= {1'b0, 25'(gmag * 10'd628), 30'b0};
				drem_q <= '0;
				dden_q <= 24'(spd_q * 8'd200);
			end
			ctas_pkg::DP_DIV_STEP: begin
				drem_q <= ge ? 24'(rem2 - {1'b0, dden_q}) : rem2[23:0];
				dnum_q <= {dnum_q[54:0], ge};
			end
			ctas_pkg::DP_RATE: begin
				if (spd_q == '0) begin
					if (g_q > 0) begin
						rate_q <= ctas_pkg::RATE_LIM;
					end else if (g_q < 0) begin
						rate_q <= -ctas_pkg::RATE_LIM;
					end else begin
						rate_q <= '0;
					end
				end else if (g_q[16]) begin
					rate_q <= -$signed({1'b0, qmag});
				end else begin
					rate_q <= $signed({1'b0, qmag});
				end
			end
			ctas_pkg::DP_ROLL_LD: begin
				x_q   <= ctas_pkg::GRAV_X;
				y_q   <= acc_q + (60'(prod_q) <<< 21);
				z_q   <= '0;
				vec_q <= 1'b1;
			end
			ctas_pkg::DP_CORDIC: begin
				if (up) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			ctas_pkg::DP_ROLL: begin
				roll_q <= 13'(tr);
			end
			ctas_pkg::DP_YAW_LD: begin
				vec_q  <= 1'b1;
				zero_q <= (vn_q == '0) && (ve_q == '0);
				if (xi < 0) begin
					if (yi >= 0) begin
						x_q <= yi;
						y_q <= -xi;
						z_q <= ctas_pkg::HALF_PI_Q30;
					end else begin
						x_q <= -yi;
						y_q <= xi;
						z_q <= -ctas_pkg::HALF_PI_Q30;
					end
				end else begin
					x_q <= xi;
					y_q <= yi;
					z_q <= '0;
				end
			end
			ctas_pkg::DP_YAW: begin
				if (zero_q) begin
					yawc_q <= '0;
				end else if (ty > 35'sd16383) begin
					yawc_q <= 15'sd16383;
				end else if (ty < -35'sd16384) begin
					yawc_q <= -15'sd16384;
				end else begin
					yawc_q <= 15'(ty);
				end
			end
			ctas_pkg::DP_SC_LD: begin
				x_q   <= 60'(KINV);
				y_q   <= '0;
				vec_q <= 1'b0;
				if (zh > ctas_pkg::HALF_PI_Q30) begin
					z_q   <= zh - ctas_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else if (zh < -ctas_pkg::HALF_PI_Q30) begin
					z_q   <= zh + ctas_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else begin
					z_q   <= zh;
					neg_q <= 1'b0;
				end
			end
			ctas_pkg::DP_MUL_S: begin
				car1_q <= carrot(prod_q);
				prod_q <= mul_p;
			end
			ctas_pkg::DP_FINISH: begin
				car2_q  <= carrot(prod_q);
				pitch_q <= -$signed({1'b0, pmc});
			end
			ctas_pkg::DP_OUT: begin
				out_q <= {7'b0, yawc_q, pitch_q, roll_q, car2_q, car1_q};
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule

>>> sv/ctas_ctrl.sv
module ctas_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_run,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ctas_pkg::dp_cmd_t  cmd
);

	localparam int NSTEPS = ctas_pkg::cordic_steps(CORDIC_STEPS);

	typedef enum logic [4:0] {
		S_IDLE, S_ENTER,
		S_MUL_PN, S_MUL_PE, S_SQ1_LD, S_SQ1, S_DIST,
		S_MUL_VN, S_MUL_VE, S_SQ2_LD, S_SQ2, S_SPD,
		S_G, S_DIV_LD, S_DIV, S_RATE, S_MUL_RL, S_MUL_RH,
		S_ROLL_LD, S_ROLL_CORD, S_ROLL,
		S_YAW_LD, S_YAW_CORD, S_YAW,
		S_SC_LD, S_SC_CORD, S_MUL_C, S_MUL_S, S_FINISH, S_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       out_valid_q;
	logic       sq_last, div_last, cord_last, out_free;

	assign sq_last   = cnt_q == 6'd15;
	assign div_last  = cnt_q == 6'd55;
	assign cord_last = cnt_q == 6'(NSTEPS - 1);
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= in_run ? S_MUL_PN : S_ENTER;
					end
				end
				S_ENTER:   state_q <= S_IDLE;
				S_MUL_PN:  state_q <= S_MUL_PE;
				S_MUL_PE:  state_q <= S_SQ1_LD;
				S_SQ1_LD: begin
					state_q <= S_SQ1;
					cnt_q   <= '0;
				end
				S_SQ1: begin
					cnt_q <= cnt_q + 6'd1;
					if (sq_last) begin
						state_q <= S_DIST;
					end
				end
				S_DIST:    state_q <= S_MUL_VN;
				S_MUL_VN:  state_q <= S_MUL_VE;
				S_MUL_VE:  state_q <= S_SQ2_LD;
				S_SQ2_LD: begin
					state_q <= S_SQ2;
					cnt_q   <= '0;
				end
				S_SQ2: begin
					cnt_q <= cnt_q + 6'd1;
					if (sq_last) begin
						state_q <= S_SPD;
					end
				end
				S_SPD:     state_q <= S_G;
				S_G:       state_q <= S_DIV_LD;
				S_DIV_LD: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						state_q <= S_RATE;
					end
				end
				S_RATE:    state_q <= S_MUL_RL;
				S_MUL_RL:  state_q <= S_MUL_RH;
				S_MUL_RH:  state_q <= S_ROLL_LD;
				S_ROLL_LD: begin
					state_q <= S_ROLL_CORD;
					cnt_q   <= '0;
				end
				S_ROLL_CORD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cord_last) begin
						state_q <= S_ROLL;
					end
				end
				S_ROLL:    state_q <= S_YAW_LD;
				S_YAW_LD: begin
					state_q <= S_YAW_CORD;
					cnt_q   <= '0;
				end
				S_YAW_CORD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cord_last) begin
						state_q <= S_YAW;
					end
				end
				S_YAW:     state_q <= S_SC_LD;
				S_SC_LD: begin
					state_q <= S_SC_CORD;
					cnt_q   <= '0;
				end
				S_SC_CORD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cord_last) begin
						state_q <= S_MUL_C;
					end
				end
				S_MUL_C:   state_q <= S_MUL_S;
				S_MUL_S:   state_q <= S_FINISH;
				S_FINISH:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.step = cnt_q[4:0];
		unique case (state_q)
			S_IDLE:      cmd.op = in_valid ? ctas_pkg::DP_LOAD : ctas_pkg::DP_NOP;
			S_ENTER:     cmd.op = ctas_pkg::DP_ENTER;
			S_MUL_PN:    cmd.op = ctas_pkg::DP_MUL_PN;
			S_MUL_PE:    cmd.op = ctas_pkg::DP_MUL_PE;
			S_SQ1_LD:    cmd.op = ctas_pkg::DP_SQRT_LD;
			S_SQ1:       cmd.op = ctas_pkg::DP_SQRT_STEP;
			S_DIST:      cmd.op = ctas_pkg::DP_DIST;
			S_MUL_VN:    cmd.op = ctas_pkg::DP_MUL_VN;
			S_MUL_VE:    cmd.op = ctas_pkg::DP_MUL_VE;
			S_SQ2_LD:    cmd.op = ctas_pkg::DP_SQRT_LD;
			S_SQ2:       cmd.op = ctas_pkg::DP_SQRT_STEP;
			S_SPD:       cmd.op = ctas_pkg::DP_SPD;
			S_G:         cmd.op = ctas_pkg::DP_G;
			S_DIV_LD:    cmd.op = ctas_pkg::DP_DIV_LD;
			S_DIV:       cmd.op = ctas_pkg::DP_DIV_STEP;
			S_RATE:      cmd.op = ctas_pkg::DP_RATE;
			S_MUL_RL:    cmd.op = ctas_pkg::DP_MUL_RL;
			S_MUL_RH:    cmd.op = ctas_pkg::DP_MUL_RH;
			S_ROLL_LD:   cmd.op = ctas_pkg::DP_ROLL_LD;
			S_ROLL_CORD: cmd.op = ctas_pkg::DP_CORDIC;
			S_ROLL:      cmd.op = ctas_pkg::DP_ROLL;
			S_YAW_LD:    cmd.op = ctas_pkg::DP_YAW_LD;
			S_YAW_CORD:  cmd.op = ctas_pkg::DP_CORDIC;
			S_YAW:       cmd.op = ctas_pkg::DP_YAW;
			S_SC_LD:     cmd.op = ctas_pkg::DP_SC_LD;
			S_SC_CORD:   cmd.op = ctas_pkg::DP_CORDIC;
			S_MUL_C:     cmd.op = ctas_pkg::DP_MUL_C;
			S_MUL_S:     cmd.op = ctas_pkg::DP_MUL_S;
			S_FINISH:    cmd.op = ctas_pkg::DP_FINISH;
			S_OUT:       cmd.op = out_free ? ctas_pkg::DP_OUT : ctas_pkg::DP_NOP;
			default:     cmd.op = ctas_pkg::DP_NOP;
		endcase
	end

	a_enter_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ENTER |-> $past(in_valid && in_ready && !in_run))
		else $error("enter state without an accepted enter beat");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	a_sqrt_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ1 || state_q == S_SQ2) |-> cnt_q < 6'd16)
		else $error("square root iteration count overrun");

	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROLL_CORD || state_q == S_YAW_CORD || state_q == S_SC_CORD)
		|-> cnt_q < 6'(NSTEPS))
		else $error("rotation iteration count overrun");

endmodule

>>> dv/tb_circle_track_attitude_setpoint.sv
module tb_circle_track_attitude_setpoint;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	localparam logic CFG_PITCH_MULT = 1'b0;
	localparam logic CFG_RADIUS     = 1'b1;
	localparam bit   OP_ENTER = 1'b0;
	localparam bit   OP_RUN   = 1'b1;

	typedef struct {
		bit                 op;
		logic signed [14:0] yaw;
		logic signed [15:0] pn;
		logic signed [15:0] pe;
		logic signed [15:0] vn;
		logic signed [15:0] ve;
	} track_item_t;

	typedef struct {
		logic signed [15:0] carrot_first;
		logic signed [15:0] carrot_second;
		logic signed [12:0] roll;
		logic signed [12:0] pitch;
		logic signed [14:0] yaw;
	} setpoint_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [14:0] cfg_data;

	circle_track_attitude_setpoint #(.CORDIC_STEPS(STEPS)) uut (.*);

	track_item_t pending_items[$];
	setpoint_t   expected_setpoints[$];
	longint      atan_tab[ctas_pkg::ATAN_SLOTS];
	longint      kinv;
	longint      pi30;
	longint      pih;
	longint      heading;
	longint      pitch_mult;
	longint      radius;
	int          in_gap;
	int          out_stall;
	bit          steady;
	int          errors;
	int          mismatches;
	int          runs_sent;
	int          enters_sent;
	int          results_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint tz_shift(longint v, int n);
		return (v >= 0) ? (v >>> n) : -((-v) >>> n);
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = longint'(1) <<< 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vector_angle(inout longint x, inout longint y, input longint z);
		longint xs;
		longint ys;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + atan_tab[i];
			end else begin
				x = x - ys; y = y + xs; z = z - atan_tab[i];
			end
		end
		return z;
	endfunction

	function automatic longint track_atan2(longint y, longint x);
		longint z;
		longint t;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = pi30 / 2;
			end else begin
				t = x; x = -y; y = t; z = -(pi30 / 2);
			end
		end
		return vector_angle(x, y, z);
	endfunction

	function automatic void heading_sincos(longint z, output longint c, output longint s);
		longint x;
		longint y;
		longint xs;
		longint ys;
		bit     flip;
		x = kinv;
		y = 0;
		flip = 0;
		if (z > pi30 / 2) begin
			z = z - pi30; flip = 1;
		end else if (z < -(pi30 / 2)) begin
			z = z + pi30; flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_tab[i];
			end else begin
				x = x + ys; y = y - xs; z = z + atan_tab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint wrap_heading(longint h);
		longint r;
		r = (h + pih) % (2 * pih);
		if (r < 0) r = r + 2 * pih;
		return r - pih;
	endfunction

	function automatic void build_tables();
		longint pi60;
		longint acc;
		longint t;
		longint x;
		longint y;
		longint z;
		pi60 = 64'sh3243F6A8885A308D;
		pi30 = (pi60 + (longint'(1) <<< 29)) >>> 30;
		pih = (pi60 + (longint'(1) <<< 38)) >>> 39;
		atan_tab[0] = ((pi60 >>> 2) + (longint'(1) <<< 29)) >>> 30;
		for (int i = 1; i < ctas_pkg::ATAN_SLOTS; i++) begin
			acc = 0;
			for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
				t = (longint'(1) <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
				acc = (k & 1) ? acc - t : acc + t;
			end
			atan_tab[i] = (acc + (longint'(1) <<< 29)) >>> 30;
		end
		x = longint'(1) <<< 30;
		y = 0;
		z = vector_angle(x, y, 0);
		if (x <= 0) x = 1;
		kinv = (longint'(1) <<< 60) / x;
	endfunction

	// Returns 1 when the item yields a setpoint; updates the kept heading.
	function automatic bit predict_setpoint(track_item_t it, output setpoint_t sp);
		longint c, s, radial, spd, g, rate, z, lim, p, rate_lim;
		sp = '{default: '0};
		rate_lim = longint'(ctas_pkg::RATE_LIM);
		if (it.op == OP_ENTER) begin
			heading = wrap_heading(longint'(it.yaw) * 512);
			return 0;
		end
		heading_sincos(heading * 512, c, s);
		sp.carrot_first = 16'(clip(-((c * radius + (longint'(1) <<< 29)) >>> 30), 16));
		sp.carrot_second = 16'(clip(-((s * radius + (longint'(1) <<< 29)) >>> 30), 16));
		radial = root_floor(longint'(it.pn) * it.pn + longint'(it.pe) * it.pe);
		spd = root_floor(longint'(it.vn) * it.vn + longint'(it.ve) * it.ve);
		g = radial - radius + 512;
		if (spd == 0) begin
			rate = (g > 0) ? rate_lim : ((g < 0) ? -rate_lim : 0);
		end else begin
			rate = (628 * g * (longint'(1) <<< 30)) / (200 * spd);
			if (rate > rate_lim) rate = rate_lim;
			if (rate < -rate_lim) rate = -rate_lim;
		end
		lim = pi30 * 7 / 36;
		z = -track_atan2(spd * rate, 981 * (longint'(1) <<< 38) / 100);
		if (z > lim) z = lim;
		if (z < -lim) z = -lim;
		sp.roll = 13'(clip(tz_shift(z, 18), 13));
		p = pitch_mult;
		if (p > tz_shift(lim, 18)) p = tz_shift(lim, 18);
		sp.pitch = 13'(clip(-p, 13));
		z = track_atan2(longint'(it.ve) * 16384, longint'(it.vn) * 16384);
		sp.yaw = 15'(clip(tz_shift(z, 18), 15));
		heading = wrap_heading(heading + (rate >>> 18));
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		track_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			in_gap        <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (in_gap > 0) begin
				in_gap        <= in_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= it.op;
				s_axis_tdata  <= {1'b0, it.ve, it.vn, it.pe, it.pn, it.yaw};
				in_gap        <= steady ? 0 : $urandom_range(0, 15);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		track_item_t it;
		setpoint_t   sp;
		setpoint_t   want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			it.op  = s_axis_tuser;
			it.yaw = s_axis_tdata[14:0];
			it.pn  = s_axis_tdata[30:15];
			it.pe  = s_axis_tdata[46:31];
			it.vn  = s_axis_tdata[62:47];
			it.ve  = s_axis_tdata[78:63];
			if (it.op == OP_RUN) runs_sent++;
			else enters_sent++;
			if (predict_setpoint(it, sp)) expected_setpoints.push_back(sp);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			sp.carrot_first  = m_axis_tdata[15:0];
			sp.carrot_second = m_axis_tdata[31:16];
			sp.roll          = m_axis_tdata[44:32];
			sp.pitch         = m_axis_tdata[57:45];
			sp.yaw           = m_axis_tdata[72:58];
			if (expected_setpoints.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("Unexpected setpoint beat: %p", sp);
			end else begin
				want = expected_setpoints.pop_front();
				if (sp != want) begin
					errors++;
					if (mismatches++ < 10)
						$display("Setpoint mismatch: expected %p, got %p", want, sp);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_stall     <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			draw = steady ? 0 : $urandom_range(0, 15);
			out_stall     <= draw;
			m_axis_tready <= (draw == 0);
		end else if (out_stall > 0) begin
			out_stall     <= out_stall - 1;
			m_axis_tready <= (out_stall == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic idx, input logic [14:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PITCH_MULT) pitch_mult = longint'(value[11:0]);
		else radius = longint'(value);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() > 0 || s_axis_tvalid || expected_setpoints.size() > 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic track_item_t make_item(bit op, int yaw, int pn, int pe, int vn, int ve);
		track_item_t it;
		it.op = op; it.yaw = 15'(yaw); it.pn = 16'(pn); it.pe = 16'(pe);
		it.vn = 16'(vn); it.ve = 16'(ve);
		return it;
	endfunction

	function automatic track_item_t random_item();
		track_item_t it;
		int          ang;
		int          mag;
		it.op  = ($urandom_range(0, 99) < 12) ? OP_ENTER : OP_RUN;
		it.yaw = ($urandom_range(0, 3) == 0) ? 15'($urandom)
			: 15'($urandom_range(0, 25736) - 12868);
		case ($urandom_range(0, 2))
			0: begin
				mag = int'(radius + $urandom_range(0, 1024) - 512);
				if (mag > 32767) mag = 32767;
				ang = $urandom_range(0, 3);
				it.pn = 16'((ang[0] ? -mag : mag) * $urandom_range(0, 10) / 10);
				it.pe = 16'((ang[1] ? -1 : 1) * root_floor(longint'(mag) * mag
					- longint'(it.pn) * it.pn));
			end
			1: begin
				it.pn = 16'($urandom_range(0, 4096) - 2048);
				it.pe = 16'($urandom_range(0, 4096) - 2048);
			end
			default: begin
				it.pn = 16'($urandom);
				it.pe = 16'($urandom);
			end
		endcase
		case ($urandom_range(0, 5))
			0: begin
				it.vn = 16'sd0;
				it.ve = 16'sd0;
			end
			1, 2: begin
				it.vn = 16'($urandom_range(0, 2048) - 1024);
				it.ve = 16'($urandom_range(0, 2048) - 1024);
			end
			3: begin
				it.vn = 16'($urandom_range(0, 6) - 3);
				it.ve = 16'($urandom_range(0, 6) - 3);
			end
			default: begin
				it.vn = 16'($urandom);
				it.ve = 16'($urandom);
			end
		endcase
		return it;
	endfunction

	task automatic run_random(input int count);
		repeat (count) pending_items.push_back(random_item());
		wait_idle();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_PITCH_MULT;
		cfg_data   = '0;
		steady     = 1'b0;
		pitch_mult = 1024;
		radius     = 768;
		heading    = 0;
		build_tables();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		pending_items.push_back(make_item(OP_RUN, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 768, 0, 0, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 256, 0, 0, 0));
		pending_items.push_back(make_item(OP_ENTER, 12868, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 0, 768, 256, 0));
		pending_items.push_back(make_item(OP_ENTER, -12868, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_RUN, 0, -32768, -32768, 1, 0));
		pending_items.push_back(make_item(OP_ENTER, 16383, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 32767, 32767, -32768, -32768));
		pending_items.push_back(make_item(OP_ENTER, -16384, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 32767, -32768, 32767, 32767));
		pending_items.push_back(make_item(OP_RUN, 0, 0, 0, -32768, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 0, 0, 0, -32768));
		pending_items.push_back(make_item(OP_RUN, 0, 0, 0, -1, 0));
		pending_items.push_back(make_item(OP_RUN, 0, 500, 500, 0, 32767));
		pending_items.push_back(make_item(OP_ENTER, 0, -1, -1, -1, -1));
		pending_items.push_back(make_item(OP_RUN, -1, -1, -1, -1, -1));
		wait_idle();
		run_random(120);

		write_reg(CFG_PITCH_MULT, 15'd0);
		write_reg(CFG_RADIUS, 15'd0);
		steady = 1'b1;
		run_random(100);
		steady = 1'b0;

		write_reg(CFG_PITCH_MULT, 15'd4095);
		write_reg(CFG_RADIUS, 15'd32767);
		run_random(120);

		write_reg(CFG_PITCH_MULT, 15'd2502);
		write_reg(CFG_RADIUS, 15'd1);
		run_random(100);

		repeat (2) begin
			write_reg(CFG_PITCH_MULT, 15'($urandom_range(0, 4095)));
			write_reg(CFG_RADIUS, 15'($urandom_range(0, 32767)));
			run_random(130);
		end

		errors += expected_setpoints.size();
		$display("Sent %0d run and %0d enter beats over six register settings, %0d setpoints checked.",
			runs_sent, enters_sent, results_seen);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors, %0d mismatches", errors, mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d setpoints outstanding", expected_setpoints.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
